// ===== rtl/cls_pkg.sv =====
`timescale 1ns / 1ps

package cls_pkg;

	localparam logic [2:0] KIND_OP    = 3'd0;
	localparam logic [2:0] KIND_KW    = 3'd1;
	localparam logic [2:0] KIND_ID    = 3'd2;
	localparam logic [2:0] KIND_NUM   = 3'd3;
	localparam logic [2:0] KIND_FLOAT = 3'd4;
	localparam logic [2:0] KIND_STR   = 3'd5;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BTICK = 8'h60;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam int NUM_KW = 5;

	// controller -> datapath
	typedef struct packed {
		logic step;
		logic rd;
		logic idx_inc;
		logic load_tok;
		logic load_op;
		logic reidle;
	} cls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic tok_end;
		logic rerun;
		logic op_emit;
		logic run_last;
	} cls_sts_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// keywords: if, for, while, do, else
	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] l;
		case (k)
			3'd0:    l = 3'd2;
			3'd1:    l = 3'd3;
			3'd2:    l = 3'd5;
			3'd3:    l = 3'd2;
			3'd4:    l = 3'd4;
			default: l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [39:0] s;
		logic [7:0]  r;
		case (k)
			3'd0:    s = {8'h00, 8'h00, 8'h00, 8'h66, 8'h69};
			3'd1:    s = {8'h00, 8'h00, 8'h72, 8'h6F, 8'h66};
			3'd2:    s = {8'h65, 8'h6C, 8'h69, 8'h68, 8'h77};
			3'd3:    s = {8'h00, 8'h00, 8'h00, 8'h6F, 8'h64};
			3'd4:    s = {8'h00, 8'h65, 8'h73, 8'h6C, 8'h65};
			default: s = '0;
		endcase
		case (p)
			3'd0:    r = s[7:0];
			3'd1:    r = s[15:8];
			3'd2:    r = s[23:16];
			3'd3:    r = s[31:24];
			3'd4:    r = s[39:32];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/cls_ctrl.sv =====
`timescale 1ns / 1ps

module cls_ctrl
	import cls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output cls_cmd_t cmd,
	input  cls_sts_t sts
);

	typedef enum logic [3:0] {
		ST_READY = 4'b0001,
		ST_RD    = 4'b0010,
		ST_PUT   = 4'b0100,
		ST_OP    = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   vld_q;
	logic   rerun_q;
	logic   out_free;

	assign out_free = !vld_q || m_tready;
	assign s_tready = (state_q == ST_READY);
	assign m_tvalid = vld_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_READY: begin
				if (s_tvalid) begin
					cmd.step = 1'b1;
					if (sts.tok_end) begin
						state_n = ST_RD;
					end else if (sts.op_emit) begin
						state_n = ST_OP;
					end
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_n = ST_PUT;
			end
			ST_PUT: begin
				if (out_free) begin
					cmd.load_tok = 1'b1;
					cmd.idx_inc  = 1'b1;
					if (sts.run_last) begin
						// terminator of a word or number is lexed again now
						cmd.reidle = rerun_q;
						state_n    = (rerun_q && sts.op_emit) ? ST_OP : ST_READY;
					end else begin
						state_n = ST_RD;
					end
				end
			end
			ST_OP: begin
				if (out_free) begin
					cmd.load_op = 1'b1;
					state_n     = ST_READY;
				end
			end
			default: state_n = ST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			vld_q   <= 1'b0;
			rerun_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_tok || cmd.load_op) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
			if (cmd.step && sts.tok_end) begin
				rerun_q <= sts.rerun;
			end
		end
	end

endmodule

// ===== rtl/cls_datapath.sv =====
`timescale 1ns / 1ps

module cls_datapath
	import cls_pkg::*;
#(
	parameter int MAX_TOKEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ch,
	input  cls_cmd_t    cmd,
	output cls_sts_t    sts,
	output logic [2:0]  kind,
	output logic [15:0] line,
	output logic [15:0] column,
	output logic [7:0]  tok_char,
	output logic        has_char,
	output logic        last
);

	localparam int LEN_W = $clog2(MAX_TOKEN + 1);
	localparam int IDX_W = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_WORD  = 3'd1,
		M_NUM   = 3'd2,
		M_FLOAT = 3'd3,
		M_STR   = 3'd4
	} mode_t;

	mode_t              mode_q, mode_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [LEN_W-1:0]   idx_q;
	logic               esc_q, esc_n;
	logic [7:0]         quote_q, quote_n;
	logic [15:0]        line_q, line_n;
	logic [15:0]        col_q, col_n;
	logic               cr_q, cr_n;
	logic [NUM_KW-1:0]  kw_q, kw_n;
	logic [2:0]         kind_q, kind_n;
	logic [7:0]         ch_q;
	logic [7:0]         rd_q;
	logic [7:0]         mem [MAX_TOKEN];

	logic [7:0]         c;
	logic               drop, do_idle, tok_end, rerun, op_emit;
	logic               app_en;
	logic [LEN_W-1:0]   app_base;
	logic               we;
	logic [5:0]         base6;
	logic [5:0]         len6;
	logic               is_kw;

	assign c    = cmd.step ? ch : ch_q;
	assign len6 = 6'(len_q);

	always_comb begin
		is_kw = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (kw_q[k] && len6 == 6'(kw_len(3'(k)))) begin
				is_kw = 1'b1;
			end
		end
	end

	always_comb begin
		mode_n   = mode_q;
		len_n    = len_q;
		esc_n    = esc_q;
		quote_n  = quote_q;
		line_n   = line_q;
		col_n    = col_q;
		cr_n     = cr_q;
		kw_n     = kw_q;
		kind_n   = kind_q;
		drop     = 1'b0;
		do_idle  = cmd.reidle;
		tok_end  = 1'b0;
		rerun    = 1'b0;
		op_emit  = 1'b0;
		app_en   = 1'b0;
		app_base = len_q;
		we       = 1'b0;
		base6    = '0;

		if (cmd.step) begin
			if (cr_q) begin
				cr_n = 1'b0;
				drop = (c == CH_LF);
			end
			if (!drop) begin
				col_n = (col_q != 16'hFFFF) ? col_q + 16'd1 : col_q;
				case (mode_q) inside
					M_STR: begin
						if (c != quote_q || esc_q) begin
							if (c != CH_BSL || esc_q) begin
								esc_n  = 1'b0;
								app_en = 1'b1;
							end else begin
								esc_n = 1'b1;
							end
						end else begin
							quote_n = '0;
							tok_end = 1'b1;
							kind_n  = KIND_STR;
							mode_n  = M_IDLE;
						end
					end
					M_WORD: begin
						if (is_alpha(c) || c == CH_UNDER) begin
							app_en = 1'b1;
						end else begin
							tok_end = 1'b1;
							rerun   = 1'b1;
							kind_n  = is_kw ? KIND_KW : KIND_ID;
						end
					end
					M_NUM, M_FLOAT: begin
						if (is_digit(c)) begin
							app_en = 1'b1;
						end else if (c == CH_DOT && mode_q == M_NUM) begin
							app_en = 1'b1;
							mode_n = M_FLOAT;
						end else begin
							tok_end = 1'b1;
							rerun   = 1'b1;
							kind_n  = (mode_q == M_FLOAT) ? KIND_FLOAT : KIND_NUM;
						end
					end
					default: do_idle = 1'b1;
				endcase
			end
		end

		if (do_idle) begin
			mode_n = M_IDLE;
			if (c == CH_CR || c == CH_LF) begin
				line_n = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;
				col_n  = '0;
				cr_n   = (c == CH_CR);
			end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
				mode_n = M_IDLE;
			end else if (c == CH_BSL && !esc_q) begin
				esc_n = 1'b1;
			end else begin
				// any token start clears the escape parity
				esc_n    = 1'b0;
				len_n    = '0;
				app_base = '0;
				if (is_alpha(c)) begin
					mode_n = M_WORD;
					app_en = 1'b1;
				end else if (is_digit(c)) begin
					mode_n = M_NUM;
					app_en = 1'b1;
				end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK) begin
					mode_n  = M_STR;
					quote_n = c;
				end else begin
					app_en  = 1'b1;
					op_emit = 1'b1;
				end
			end
		end

		if (app_en && app_base < LEN_W'(MAX_TOKEN)) begin
			we    = 1'b1;
			len_n = app_base + LEN_W'(1);
			base6 = 6'(app_base);
			for (int k = 0; k < NUM_KW; k++) begin
				kw_n[k] = (base6 < 6'(kw_len(3'(k)))) && (c == kw_char(3'(k), base6[2:0]))
					&& (base6 == 6'd0 || kw_q[k]);
			end
		end
	end

	assign sts.tok_end  = tok_end;
	assign sts.rerun    = rerun;
	assign sts.op_emit  = op_emit;
	assign sts.run_last = (len_q == '0) || (LEN_W'(idx_q + LEN_W'(1)) == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			len_q   <= '0;
			esc_q   <= 1'b0;
			quote_q <= '0;
			line_q  <= 16'd1;
			col_q   <= '0;
			cr_q    <= 1'b0;
			kw_q    <= '0;
			idx_q   <= '0;
		end else begin
			mode_q  <= mode_n;
			len_q   <= len_n;
			esc_q   <= esc_n;
			quote_q <= quote_n;
			line_q  <= line_n;
			col_q   <= col_n;
			cr_q    <= cr_n;
			kw_q    <= kw_n;
			if (cmd.step) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[app_base[IDX_W-1:0]] <= c;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q[IDX_W-1:0]];
		end
		if (cmd.step) begin
			ch_q   <= ch;
			kind_q <= kind_n;
		end
	end

	// result register; line and column are live, the token run is sent before
	// the terminator is lexed again
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			kind     <= kind_q;
			line     <= line_q;
			column   <= col_q;
			tok_char <= (len_q == '0) ? 8'h00 : rd_q;
			has_char <= (len_q != '0);
			last     <= sts.run_last;
		end else if (cmd.load_op) begin
			kind     <= KIND_OP;
			line     <= line_q;
			column   <= col_q;
			tok_char <= ch_q;
			has_char <= 1'b1;
			last     <= 1'b1;
		end
	end

endmodule

// ===== rtl/char_stream_lexer_core.sv =====
`timescale 1ns / 1ps
// Bytes are accepted in ST_READY; a byte that yields an operator has its result
// registered in ST_OP once the output is free, then ST_READY takes the next byte.
// Each character of a token run passes through ST_RD and ST_PUT: the token buffer
// has one read port, read in ST_RD and registered into the result in ST_PUT.
// Throughput is one byte per cycle while a token is collected; an operator or a
// token run holds off the next byte until its results are registered.
// arst_n clears the controller and the lexer state (line 1, column 0) at once.

module char_stream_lexer_core
	import cls_pkg::*;
#(
	parameter int MAX_TOKEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [15:0] line, [31:16] column, [39:32] tok_char
	output logic [3:0]  m_tuser,  // [2:0] kind, [3] has_char
	output logic        m_tlast
);

	cls_cmd_t    cmd;
	cls_sts_t    sts;
	logic [2:0]  kind;
	logic [15:0] line;
	logic [15:0] column;
	logic [7:0]  tok_char;
	logic        has_char;

	cls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cls_datapath #(
		.MAX_TOKEN (MAX_TOKEN)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.kind     (kind),
		.line     (line),
		.column   (column),
		.tok_char (tok_char),
		.has_char (has_char),
		.last     (m_tlast)
	);

	assign m_tdata = {tok_char, column, line};
	assign m_tuser = {has_char, kind};

endmodule

// ===== rtl/cls_checker.sv =====
`timescale 1ns / 1ps

module cls_checker
	import cls_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// an empty string is a single result with no character
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] |-> m_tlast && m_tuser[2:0] == KIND_STR
			&& m_tdata[39:32] == 8'h00)
		else $error("empty token malformed");

	// operators are always one-character runs
	a_op_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == KIND_OP |-> m_tlast && m_tuser[3])
		else $error("operator run longer than one");

	// line numbering starts at one and saturates, never wraps to zero
	a_line_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'd0)
		else $error("line number zero");

endmodule

bind char_stream_lexer_core cls_checker u_cls_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cls_pkg::*;

	localparam int TOK_MAX     = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int RAND_ITEMS  = 440;

	typedef enum logic [2:0] {LX_IDLE, LX_WORD, LX_NUM, LX_FLOAT, LX_STR} lex_mode_t;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] line_no;
		logic [15:0] col_no;
		logic [7:0]  chr;
		logic        has_chr;
		logic        is_last;
	} tok_char_t;

	// Tracks the lexer state byte by byte and holds the token characters still owed.
	class token_tracker;
		lex_mode_t   mode;
		logic [7:0]  text [TOK_MAX];
		int unsigned len;
		logic        esc;
		logic [7:0]  quote;
		logic [15:0] line_no;
		logic [15:0] col_no;
		logic        cr_pend;
		tok_char_t   expected_chars[$];
		string       kw_words[5];
		int          errors;
		int          checked;
		int          runs[6];

		function new();
			mode = LX_IDLE;
			len = 0;
			esc = 1'b0;
			quote = 8'h00;
			line_no = 16'd1;
			col_no = 16'd0;
			cr_pend = 1'b0;
			errors = 0;
			checked = 0;
			foreach (runs[i]) runs[i] = 0;
			kw_words = '{"if", "for", "while", "do", "else"};
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit numeral(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void push(logic [2:0] kind, logic [7:0] chr, logic has, logic lst);
			tok_char_t t;
			t.kind = kind;
			t.line_no = line_no;
			t.col_no = col_no;
			t.chr = chr;
			t.has_chr = has;
			t.is_last = lst;
			expected_chars.push_back(t);
		endfunction

		// anything past TOK_MAX is dropped
		function void keep(logic [7:0] c);
			if (len < TOK_MAX) begin
				text[len] = c;
				len++;
			end
		endfunction

		function bit keyword_hit();
			bit hit;
			bit same;
			hit = 0;
			for (int k = 0; k < 5; k++) begin
				if (kw_words[k].len() == len) begin
					same = 1;
					for (int i = 0; i < len; i++)
						if (text[i] != kw_words[k][i]) same = 0;
					if (same) hit = 1;
				end
			end
			return hit;
		endfunction

		function void flush_token(logic [2:0] kind);
			if (len == 0) begin
				push(kind, 8'h00, 1'b0, 1'b1);
			end else begin
				for (int i = 0; i < len; i++)
					push(kind, text[i], 1'b1, i == len - 1);
			end
		endfunction

		function void begin_token(lex_mode_t m);
			mode = m;
			len = 0;
			esc = 1'b0;
		endfunction

		function void lex_byte(logic [7:0] c);
			if (cr_pend) begin
				cr_pend = 1'b0;
				if (c == CH_LF) return;
			end
			if (col_no != 16'hFFFF) col_no++;
			if (mode == LX_STR) begin
				if (c != quote || esc) begin
					if (c != CH_BSL || esc) begin
						esc = 1'b0;
						keep(c);
					end else begin
						esc = 1'b1;
					end
				end else begin
					quote = 8'h00;
					flush_token(KIND_STR);
					mode = LX_IDLE;
				end
				return;
			end
			if (mode == LX_WORD) begin
				if (letter(c) || c == CH_UNDER) begin
					keep(c);
					return;
				end
				flush_token(keyword_hit() ? KIND_KW : KIND_ID);
			end else if (mode == LX_NUM || mode == LX_FLOAT) begin
				if (numeral(c)) begin
					keep(c);
					return;
				end
				if (c == CH_DOT && mode == LX_NUM) begin
					keep(c);
					mode = LX_FLOAT;
					return;
				end
				flush_token(mode == LX_FLOAT ? KIND_FLOAT : KIND_NUM);
			end
			// the terminator of a word or number falls through and is lexed again
			mode = LX_IDLE;
			if (c == CH_CR || c == CH_LF) begin
				if (line_no != 16'hFFFF) line_no++;
				col_no = 16'd0;
				if (c == CH_CR) cr_pend = 1'b1;
				return;
			end
			if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return;
			if (c == CH_BSL) begin
				esc = ~esc;
				if (esc) return;
			end
			if (letter(c)) begin
				begin_token(LX_WORD);
				keep(c);
			end else if (numeral(c)) begin
				begin_token(LX_NUM);
				keep(c);
			end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK) begin
				begin_token(LX_STR);
				quote = c;
			end else begin
				begin_token(LX_IDLE);
				keep(c);
				push(KIND_OP, c, 1'b1, 1'b1);
			end
		endfunction

		function void check_char(logic [2:0] kind, logic [15:0] ln, logic [15:0] cl,
				logic [7:0] chr, logic has, logic lst);
			tok_char_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected result: kind %0d char %02h", kind, chr);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			checked++;
			if (want.is_last) runs[want.kind]++;
			if (kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (ln !== want.line_no) begin
				$error("line: expected %0d, got %0d", want.line_no, ln);
				errors++;
			end
			if (cl !== want.col_no) begin
				$error("column: expected %0d, got %0d", want.col_no, cl);
				errors++;
			end
			if (chr !== want.chr) begin
				$error("tok_char: expected %02h, got %02h", want.chr, chr);
				errors++;
			end
			if (has !== want.has_chr) begin
				$error("has_char: expected %0d, got %0d", want.has_chr, has);
				errors++;
			end
			if (lst !== want.is_last) begin
				$error("last: expected %0d, got %0d", want.is_last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	token_tracker board;
	int  burst_left;
	bit  steady;
	int  items_sent;
	int  bytes_sent;
	int  quiet;
	int  rx_cycle;
	int  rx_style;

	char_stream_lexer_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: switches between always ready, random and sparse
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 300 == 0) rx_style = $urandom_range(0, 2);
		case (rx_style)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 2) != 0);
			default: m_tready <= (rx_cycle % 8 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_char(m_tuser[2:0], m_tdata[15:0], m_tdata[31:16], m_tdata[39:32],
				m_tuser[3], m_tlast);
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: %0d results still owed", board.expected_chars.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] c);
		int gap;
		if (burst_left <= 0) begin
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.lex_byte(c);
		burst_left--;
		bytes_sent++;
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
		return base + 8'($urandom_range(0, 25));
	endfunction

	function automatic int rand_len();
		return ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
	endfunction

	task automatic send_random_token();
		int         pick;
		int         n;
		logic [7:0] c;
		logic [7:0] q;
		string      ops;
		ops = "+-*/=<>!&|;,(){}[]#@$%^~?:._\\";
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			send_text(board.kw_words[$urandom_range(0, 4)]);
		end else if (pick < 27) begin
			n = rand_len();
			send_byte(rand_letter());
			for (int i = 1; i < n; i++)
				send_byte($urandom_range(0, 5) == 0 ? CH_UNDER : rand_letter());
		end else if (pick < 39) begin
			n = rand_len();
			for (int i = 0; i < n; i++) send_byte(8'h30 + 8'($urandom_range(0, 9)));
		end else if (pick < 49) begin
			n = rand_len();
			for (int i = 0; i < n; i++) send_byte(8'h30 + 8'($urandom_range(0, 9)));
			send_byte(CH_DOT);
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++) send_byte(8'h30 + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 3) == 0) begin
				send_byte(CH_DOT);
				send_byte(8'h30 + 8'($urandom_range(0, 9)));
			end
		end else if (pick < 61) begin
			case ($urandom_range(0, 2))
				0:       q = CH_DQUOTE;
				1:       q = CH_SQUOTE;
				default: q = CH_BTICK;
			endcase
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
			send_byte(q);
			for (int i = 0; i < n; i++) begin
				c = 8'($urandom_range(0, 255));
				if (c == q || c == CH_BSL || $urandom_range(0, 9) == 0) send_byte(CH_BSL);
				send_byte(c);
			end
			send_byte(q);
		end else if (pick < 73) begin
			send_byte(ops[$urandom_range(0, ops.len() - 1)]);
		end else if (pick < 85) begin
			case ($urandom_range(0, 7))
				0:       send_byte(CH_SPACE);
				1:       send_byte(CH_TAB);
				2:       send_byte(CH_VT);
				3:       send_byte(CH_FF);
				4:       send_byte(CH_CR);
				5:       send_byte(CH_LF);
				default: begin
					send_byte(CH_CR);
					send_byte(CH_LF);
				end
			endcase
		end else if (pick < 93) begin
			send_byte(8'($urandom_range(0, 1) ? $urandom_range(128, 255)
				: $urandom_range(0, 8)));
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1)) send_byte(CH_SPACE);
	endtask

	initial begin
		board = new();
		burst_left = 0;
		steady = 0;
		items_sent = 0;
		bytes_sent = 0;
		quiet = 0;
		rx_cycle = 0;
		rx_style = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		m_tready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keyword, identifier ended by a digit, float ended by a second dot
		send_text("if x9.5.");
		// escaped backslash while idle, then CRLF as one newline
		send_byte(CH_BSL);
		send_byte(CH_BSL);
		send_byte(CH_CR);
		send_byte(CH_LF);
		// underscore as operator, string with escaped quote
		send_text("_\"a\\\"\"");
		// lone CR, word ended by a tab, byte extremes
		send_byte(CH_CR);
		send_text("a");
		send_byte(CH_TAB);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_LF);
		// empty string
		send_byte(CH_BTICK);
		send_byte(CH_BTICK);

		while (items_sent < RAND_ITEMS) begin
			if ($urandom_range(0, 39) == 0) steady = !steady;
			send_random_token();
		end

		send_text("x1 2.5;");
		send_byte(";");
		s_tvalid <= 1'b0;

		while (board.expected_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("lexed %0d bytes of mixed tokens, blanks and newlines, %0d result chars checked",
			bytes_sent, board.checked);
		$display("token runs: %0d op, %0d keyword, %0d ident, %0d number, %0d float, %0d string",
			board.runs[KIND_OP], board.runs[KIND_KW], board.runs[KIND_ID],
			board.runs[KIND_NUM], board.runs[KIND_FLOAT], board.runs[KIND_STR]);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cls_pkg.sv
rtl/cls_ctrl.sv
rtl/cls_datapath.sv
rtl/char_stream_lexer_core.sv
rtl/cls_checker.sv
dv/tb.sv
